[src/pep_pkg.sv]
// ----------------------------------------------------------------------------
// pep_pkg
// Shared types and constants for the prefix expression evaluator: character
// codes, status codes, controller states and the controller/datapath links.
// ----------------------------------------------------------------------------
package pep_pkg;

	localparam int PEP_STACK_DEPTH = 16;
	localparam int PEP_DATA_W      = 8;

	localparam logic [7:0] ASCII_0     = 8'h30;
	localparam logic [7:0] ASCII_9     = 8'h39;
	localparam logic [7:0] ASCII_PLUS  = 8'h2B;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] ASCII_MUL   = 8'h2A;
	localparam logic [7:0] ASCII_DIV   = 8'h2F;
	localparam logic [7:0] ASCII_MOD   = 8'h25;
	localparam logic [7:0] ASCII_XOR   = 8'h5E;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_DIVZERO   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WAIT,
		S_POP_B,
		S_CALC,
		S_DIV,
		S_PUSH,
		S_END,
		S_FINAL
	} pep_state_t;

	typedef struct packed {
		logic load;
		logic pop_a;
		logic pop_b;
		logic calc;
		logic div_start;
		logic div_take;
		logic push;
		logic emit;
	} pep_cmd_t;

	typedef struct packed {
		logic is_digit;
		logic is_op;
		logic is_div;
		logic last;
		logic rhs_zero;
		logic div_done;
		logic out_busy;
	} pep_sts_t;

endpackage

[src/pep_divider.sv]
// ----------------------------------------------------------------------------
// pep_divider
// Iterative signed 8-bit divider, one quotient bit per cycle, truncating
// toward zero; remainder takes the sign of the dividend.
// ----------------------------------------------------------------------------
module pep_divider
	import pep_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [PEP_DATA_W-1:0] dividend,
	input  logic signed [PEP_DATA_W-1:0] divisor,
	output logic                         done,
	output logic signed [PEP_DATA_W-1:0] quotient,
	output logic signed [PEP_DATA_W-1:0] remainder
);

	localparam int CNT_W = $clog2(PEP_DATA_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PEP_DATA_W-1:0] rem_q;
	logic [PEP_DATA_W-1:0] quo_q;
	logic [PEP_DATA_W-1:0] dsr_q;
	logic                  neg_quo_q;
	logic                  neg_rem_q;

	logic [PEP_DATA_W-1:0] mag_a;
	logic [PEP_DATA_W-1:0] mag_b;
	logic [PEP_DATA_W:0]   shifted;
	logic                  ge;

	// magnitude of -128 is 128, which still fits unsigned
	assign mag_a   = dividend[PEP_DATA_W-1] ? PEP_DATA_W'(-dividend) : dividend;
	assign mag_b   = divisor[PEP_DATA_W-1] ? PEP_DATA_W'(-divisor) : divisor;
	assign shifted = {rem_q, quo_q[PEP_DATA_W-1]};
	assign ge      = shifted >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PEP_DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= mag_a;
			dsr_q     <= mag_b;
			neg_quo_q <= dividend[PEP_DATA_W-1] ^ divisor[PEP_DATA_W-1];
			neg_rem_q <= dividend[PEP_DATA_W-1];
		end else if (busy_q) begin
			rem_q <= ge ? PEP_DATA_W'(shifted - {1'b0, dsr_q}) : shifted[PEP_DATA_W-1:0];
			quo_q <= {quo_q[PEP_DATA_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = neg_quo_q ? PEP_DATA_W'(-quo_q) : quo_q;
	assign remainder = neg_rem_q ? PEP_DATA_W'(-rem_q) : rem_q;

endmodule

[src/pep_datapath.sv]
// ----------------------------------------------------------------------------
// pep_datapath
// Value stack memory, stack count, error status, operand registers, ALU,
// divider and the output register of the evaluator.
// ----------------------------------------------------------------------------
module pep_datapath
	import pep_pkg::*;
#(
	parameter int STACK_DEPTH = PEP_STACK_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pep_cmd_t              cmd,
	output pep_sts_t              sts,
	input  logic [7:0]            in_token,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PEP_DATA_W-1:0] out_result,
	output logic [1:0]            out_status
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [PEP_DATA_W-1:0] mem [STACK_DEPTH];
	logic [PEP_DATA_W-1:0] rd_q;
	logic [CW-1:0]         count_q;
	logic [1:0]            err_q;
	logic [7:0]            token_q;
	logic                  last_q;
	logic signed [PEP_DATA_W-1:0] lhs_q;
	logic signed [PEP_DATA_W-1:0] rhs_q;
	logic [PEP_DATA_W-1:0] res_q;
	logic                  out_valid_q;
	logic [PEP_DATA_W-1:0] out_result_q;
	logic [1:0]            out_status_q;

	logic [CW-1:0]         count_dec;
	logic [AW-1:0]         rd_addr;
	logic                  empty;
	logic                  full;
	logic                  is_digit;
	logic                  is_op;
	logic                  is_div;
	logic [PEP_DATA_W-1:0] push_val;
	logic [PEP_DATA_W-1:0] pop_val;
	logic [2*PEP_DATA_W-1:0] prod;
	logic [PEP_DATA_W-1:0] alu;
	logic                  div_done;
	logic signed [PEP_DATA_W-1:0] div_quo;
	logic signed [PEP_DATA_W-1:0] div_rem;

	assign count_dec = count_q - CW'(1);
	assign rd_addr   = count_dec[AW-1:0];
	assign empty     = count_q == '0;
	assign full      = count_q == CW'(STACK_DEPTH);
	assign pop_val   = empty ? '0 : rd_q;

	always_comb begin
		is_digit = token_q inside {[ASCII_0:ASCII_9]};
		is_op    = token_q inside {ASCII_PLUS, ASCII_MINUS, ASCII_MUL,
			ASCII_DIV, ASCII_MOD, ASCII_XOR};
		is_div   = token_q inside {ASCII_DIV, ASCII_MOD};
	end

	assign push_val = is_digit ? PEP_DATA_W'(token_q - ASCII_0) : res_q;
	assign prod     = lhs_q * rhs_q;

	always_comb begin
		case (token_q)
			ASCII_PLUS:  alu = PEP_DATA_W'(lhs_q + rhs_q);
			ASCII_MINUS: alu = PEP_DATA_W'(lhs_q - rhs_q);
			ASCII_MUL:   alu = prod[PEP_DATA_W-1:0];
			ASCII_XOR:   alu = lhs_q ^ rhs_q;
			default:     alu = '0;
		endcase
	end

	pep_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (lhs_q),
		.divisor   (rhs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// stack memory, read port follows the top of stack every cycle
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.push && !full) begin
			mem[count_q[AW-1:0]] <= push_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.pop_a || cmd.pop_b) begin
				if (empty) begin
					if (err_q == ERR_NONE) err_q <= ERR_UNDERFLOW;
				end else begin
					count_q <= count_dec;
				end
			end
			if (cmd.calc && is_div && rhs_q == '0 && err_q == ERR_NONE) begin
				err_q <= ERR_DIVZERO;
			end
			if (cmd.push) begin
				if (full) begin
					if (err_q == ERR_NONE) err_q <= ERR_OVERFLOW;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				err_q       <= ERR_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			token_q <= in_token;
			last_q  <= in_last;
		end
		if (cmd.pop_a) lhs_q <= pop_val;
		if (cmd.pop_b) rhs_q <= pop_val;
		if (cmd.calc) res_q <= alu;
		if (cmd.div_take) begin
			res_q <= (token_q == ASCII_DIV) ? div_quo : div_rem;
		end
		if (cmd.emit) begin
			out_result_q <= pop_val;
			out_status_q <= (empty && err_q == ERR_NONE) ? ERR_UNDERFLOW : err_q;
		end
	end

	always_comb begin
		sts.is_digit = is_digit;
		sts.is_op    = is_op;
		sts.is_div   = is_div;
		sts.last     = last_q;
		sts.rhs_zero = rhs_q == '0;
		sts.div_done = div_done;
		sts.out_busy = out_valid_q;
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_result_q;
	assign out_status = out_status_q;

endmodule

[src/pep_controller.sv]
// ----------------------------------------------------------------------------
// pep_controller
// Sequencer of the evaluator: decodes each character and steps the datapath
// through pops, the operation, the push and the final pop.
// ----------------------------------------------------------------------------
module pep_controller
	import pep_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  pep_sts_t sts,
	output pep_cmd_t cmd
);

	pep_state_t state_q;
	pep_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = sts.is_op ? S_WAIT : S_END;
			end
			S_WAIT:  state_d = S_POP_B;
			S_POP_B: state_d = S_CALC;
			S_CALC: begin
				state_d = (sts.is_div && !sts.rhs_zero) ? S_DIV : S_PUSH;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_PUSH;
			end
			S_PUSH: state_d = S_END;
			S_END: begin
				state_d = sts.last ? S_FINAL : S_IDLE;
			end
			S_FINAL: begin
				if (!sts.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				cmd.push  = sts.is_digit;
				cmd.pop_a = sts.is_op;
			end
			S_POP_B: cmd.pop_b = 1'b1;
			S_CALC: begin
				cmd.calc      = 1'b1;
				cmd.div_start = sts.is_div && !sts.rhs_zero;
			end
			S_DIV:   cmd.div_take = sts.div_done;
			S_PUSH:  cmd.push = 1'b1;
			S_FINAL: cmd.emit = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

[src/prefix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// prefix_expression_evaluator
// Stack evaluator for prefix expressions fed one character per transaction.
// ----------------------------------------------------------------------------
// Characters arrive last to first; s_tlast marks the final one. Digits push
// their value, + - * / % ^ pop left then right operand and push the 8-bit
// wrapped result, anything else is ignored. After the final character the top
// of stack is sent on the master side with a status (0 ok, 1 underflow,
// 2 overflow, 3 divide by zero, first error kept) and the stack is cleared.
// One character is handled at a time: / and % run the 8-step bit-serial
// divider, which is skipped with a zero divisor; after the final character the
// result is sent once the previous result has been taken. Operands are read
// through the one-port registered stack read.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator
	import pep_pkg::*;
#(
	parameter int STACK_DEPTH = PEP_STACK_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] token
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] result, [9:8] status, [15:10] zero
);

	pep_cmd_t              cmd;
	pep_sts_t              sts;
	logic [PEP_DATA_W-1:0] result;
	logic [1:0]            status;

	pep_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pep_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_token   (s_tdata),
		.in_last    (s_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result),
		.out_status (status)
	);

	assign m_tdata = {6'b0, status, result};

endmodule

[tb/sv/tb_prefix_expression_evaluator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prefix_expression_evaluator
// Self-checking testbench for the prefix expression evaluator.
// ----------------------------------------------------------------------------
// A short table of hand-picked expressions comes first: extremes, every
// operator, operand order, underflow, divide by zero and a wrapping divide.
// Random expressions follow, mostly well formed with random digits and
// operators, some deep enough to overflow the stack, the rest broken or pure
// noise. A behavioural stack model predicts every result; results are
// compared field by field in order. Four idling phases vary the gaps on the
// slave side and the back-pressure on the master side.
// ----------------------------------------------------------------------------
module tb_prefix_expression_evaluator
	import pep_pkg::*;
;

	localparam int RANDOM_ITEMS    = 726;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int MAX_REPORTS     = 10;
	localparam int DIRECTED_COUNT  = 24;

	typedef struct packed {
		logic signed [7:0] value;
		logic [1:0]        status;
	} expr_result_t;

	typedef struct packed {
		logic [7:0] token;
		logic       is_last;
		logic       fixed;    // expectation typed in below rather than predicted
		logic [7:0] value;
		logic [1:0] status;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] token
	logic        s_tlast = 1'b0; // last
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [7:0] result, [9:8] status, [15:10] zero

	// stack model state
	logic [7:0] model_stack [PEP_STACK_DEPTH];
	int         model_depth = 0;
	logic [1:0] model_err = ERR_NONE;

	expr_result_t pending_results[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int results_checked = 0;
	int items_sent = 0;
	int expressions_sent = 0;
	int overflow_seen = 0;

	stim_row_t directed_rows [DIRECTED_COUNT] = '{
		'{ASCII_0 + 8'd7, 1'b1, 1'b1, 8'd7, ERR_NONE},
		'{8'hFF, 1'b1, 1'b1, 8'd0, ERR_UNDERFLOW},
		'{ASCII_0, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd5, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_DIV, 1'b1, 1'b1, 8'd0, ERR_DIVZERO},
		'{ASCII_0, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd9, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_MOD, 1'b1, 1'b1, 8'd0, ERR_DIVZERO},
		'{ASCII_0 + 8'd3, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd9, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_MINUS, 1'b1, 1'b1, 8'd6, ERR_NONE},
		'{ASCII_0 + 8'd5, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd3, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_XOR, 1'b1, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_PLUS, 1'b1, 1'b1, 8'd0, ERR_UNDERFLOW},
		// (-128) / (-1) built from digits, wraps back to -128
		'{ASCII_0 + 8'd1, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_MINUS, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd8, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd8, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_MUL, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_0 + 8'd2, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_MUL, 1'b0, 1'b0, 8'd0, ERR_NONE},
		'{ASCII_DIV, 1'b1, 1'b1, 8'h80, ERR_NONE}
	};

	prefix_expression_evaluator i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic bit is_digit(input logic [7:0] tok);
		return tok >= ASCII_0 && tok <= ASCII_9;
	endfunction

	function automatic bit is_operator(input logic [7:0] tok);
		return tok == ASCII_PLUS || tok == ASCII_MINUS || tok == ASCII_MUL ||
			tok == ASCII_DIV || tok == ASCII_MOD || tok == ASCII_XOR;
	endfunction

	function automatic void record_error(input logic [1:0] code);
		if (model_err == ERR_NONE)
			model_err = code;
	endfunction

	function automatic void stack_push_value(input logic [7:0] v);
		if (model_depth >= PEP_STACK_DEPTH) begin
			record_error(ERR_OVERFLOW);
		end else begin
			model_stack[model_depth] = v;
			model_depth++;
		end
	endfunction

	function automatic logic signed [7:0] stack_pop_value();
		if (model_depth == 0) begin
			record_error(ERR_UNDERFLOW);
			return 8'sd0;
		end
		model_depth--;
		return model_stack[model_depth];
	endfunction

	// advances the stack model by one character; returns 1 when a result is due
	function automatic bit evaluate_character(input logic [7:0] tok, input logic lst,
			output expr_result_t r);
		int lhs;
		int rhs;
		int val;
		r = '0;
		if (is_digit(tok)) begin
			stack_push_value(tok - ASCII_0);
		end else if (is_operator(tok)) begin
			lhs = stack_pop_value();
			rhs = stack_pop_value();
			val = 0;
			case (tok)
				ASCII_PLUS:  val = lhs + rhs;
				ASCII_MINUS: val = lhs - rhs;
				ASCII_MUL:   val = lhs * rhs;
				ASCII_XOR:   val = lhs ^ rhs;
				ASCII_DIV: begin
					if (rhs == 0) record_error(ERR_DIVZERO);
					else val = lhs / rhs;
				end
				default: begin
					if (rhs == 0) record_error(ERR_DIVZERO);
					else val = lhs % rhs;
				end
			endcase
			stack_push_value(val[7:0]);
		end
		if (!lst)
			return 1'b0;
		r.value = stack_pop_value();
		r.status = model_err;
		model_depth = 0;
		model_err = ERR_NONE;
		return 1'b1;
	endfunction

	task automatic send_character(input logic [7:0] tok, input logic lst, input bit fixed,
			input expr_result_t fixed_result);
		expr_result_t predicted;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= tok;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// transaction accepted at this edge
		items_sent++;
		if (evaluate_character(tok, lst, predicted)) begin
			if (predicted.status == ERR_OVERFLOW)
				overflow_seen++;
			pending_results.push_back(fixed ? fixed_result : predicted);
			expressions_sent++;
		end
	endtask

	function automatic logic [7:0] random_digit();
		return ASCII_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(0, 5))
			0: return ASCII_PLUS;
			1: return ASCII_MINUS;
			2: return ASCII_MUL;
			3: return ASCII_DIV;
			4: return ASCII_MOD;
			default: return ASCII_XOR;
		endcase
	endfunction

	task automatic send_random_expression();
		logic [7:0] seq[$];
		int shape;
		int operands;
		int depth;
		int pushed;
		int len;
		int sel;
		bit deep;
		shape = $urandom_range(0, 99);
		if (shape < 75) begin
			// well formed, fed last character first, i.e. in postfix order
			sel = $urandom_range(0, 99);
			operands = (sel < 70) ? $urandom_range(1, 5) :
				(sel < 92) ? $urandom_range(6, 16) : $urandom_range(17, 19);
			deep = (operands > PEP_STACK_DEPTH) || ($urandom_range(0, 9) == 0);
			depth = 0;
			pushed = 0;
			while (!(pushed == operands && depth == 1)) begin
				if (pushed < operands && (depth < 2 || deep || $urandom_range(0, 1))) begin
					seq.push_back(random_digit());
					pushed++;
					depth++;
				end else begin
					seq.push_back(random_operator());
					depth--;
				end
			end
		end else if (shape < 90) begin
			len = $urandom_range(1, 8);
			repeat (len) begin
				sel = $urandom_range(0, 2);
				seq.push_back(sel == 0 ? random_digit() :
					sel == 1 ? random_operator() : 8'($urandom_range(0, 255)));
			end
		end else begin
			len = $urandom_range(1, 4);
			repeat (len) seq.push_back(8'($urandom_range(0, 255)));
		end
		foreach (seq[i]) begin
			if ($urandom_range(0, 11) == 0)
				send_character(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
			send_character(seq[i], i == seq.size() - 1, 1'b0, '0);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		expr_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transaction: data %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[7:0] !== want.value || m_tdata[9:8] !== want.status ||
						m_tdata[15:10] !== 6'd0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: expected value %0d status %0d, got value %0d status %0d pad %h",
							results_checked, want.value, want.status,
							$signed(m_tdata[7:0]), m_tdata[9:8], m_tdata[15:10]);
				end
			end
		end
	end

	initial begin
		int target;
		expr_result_t fixed_result;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			fixed_result.value  = directed_rows[i].value;
			fixed_result.status = directed_rows[i].status;
			send_character(directed_rows[i].token, directed_rows[i].is_last,
				directed_rows[i].fixed, fixed_result);
		end

		items_sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 49; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 49; end
				default: begin gap_pct = 37; stall_pct = 37; end
			endcase
			target = (phase + 1) * RANDOM_ITEMS / 4;
			while (items_sent < target)
				send_random_expression();
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d expressions, %0d random characters,",
			expressions_sent, items_sent);
		$display("%0d results checked, %0d ending in stack overflow, %0d mismatches",
			results_checked, overflow_seen, mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
src/pep_pkg.sv
src/pep_divider.sv
src/pep_datapath.sv
src/pep_controller.sv
src/prefix_expression_evaluator.sv
tb/sv/tb_prefix_expression_evaluator.sv
